FILE: rtl/assert_macros.svh
// Assertion helpers. The enclosing module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/pts_pkg.sv
package pts_pkg;

  localparam int KIND_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int ID_W     = 8;
  localparam int GRANT_W  = 3;
  localparam int MASK_W   = 8;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [ID_W-1:0]     slot_id_t;
  typedef logic [GRANT_W-1:0]  grant_t;
  typedef logic [MASK_W-1:0]   mask_t;

  localparam kind_t KIND_REGISTER = 2'd0;
  localparam kind_t KIND_REMOVE   = 2'd1;
  localparam kind_t KIND_TICK     = 2'd2;

  // One decoded transaction applied to the slot bank.
  typedef struct packed {
    logic     reg_en;
    logic     rem_en;
    logic     tick_en;
    period_t  period;
    slot_id_t slot_id;
  } slot_cmd_t;

endpackage

FILE: rtl/pts_alloc.sv
module pts_alloc #(
  parameter int SLOTS = 8
) (
  input  logic [SLOTS-1:0]    active_i,
  output logic [SLOTS-1:0]    grant_onehot_o,
  output pts_pkg::grant_t     grant_idx_o,
  output logic                full_o
);
  import pts_pkg::*;

  logic [SLOTS-1:0] free;

  // lowest set bit of the free vector
  assign free           = ~active_i;
  assign grant_onehot_o = free & (~free + {{(SLOTS-1){1'b0}}, 1'b1});
  assign full_o         = ~|free;

  always_comb begin
    grant_idx_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (grant_onehot_o[i]) begin
        grant_idx_o = grant_idx_o | GRANT_W'(i);
      end
    end
  end

endmodule

FILE: rtl/pts_slot_bank.sv
module pts_slot_bank #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pts_pkg::slot_cmd_t  cmd_i,
  input  logic [SLOTS-1:0]    grant_onehot_i,
  output logic [SLOTS-1:0]    active_o,
  output logic [SLOTS-1:0]    fire_o
);
  import pts_pkg::*;

  logic [SLOTS-1:0] active_r;
  period_t          period_r [SLOTS];
  period_t          count_r  [SLOTS];
  period_t          count_inc [SLOTS];
  logic [SLOTS-1:0] hit;
  logic [SLOTS-1:0] rem_hit;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      count_inc[i] = count_r[i] + PERIOD_W'(1);
      hit[i]       = active_r[i] && (count_inc[i] >= period_r[i]);
      rem_hit[i]   = cmd_i.rem_en && (cmd_i.slot_id == ID_W'(i));
    end
  end

  assign active_o = active_r;
  assign fire_o   = cmd_i.tick_en ? hit : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        period_r[i] <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd_i.reg_en && grant_onehot_i[i]) begin
          active_r[i] <= 1'b1;
          period_r[i] <= cmd_i.period;
          count_r[i]  <= '0;
        end else if (rem_hit[i]) begin
          active_r[i] <= 1'b0;
          period_r[i] <= '0;
        end else if (cmd_i.tick_en) begin
          count_r[i] <= hit[i] ? '0 : count_inc[i];
        end
      end
    end
  end

endmodule

FILE: rtl/periodic_timer_slot_table.sv
// Periodic timer slot table. Each transaction is register (claim the lowest
// free slot with a period), remove (free a slot by number, numbers at or
// above SLOTS ignored) or tick (advance every count, report expired active
// slots in fire_mask and restart them). Exactly one result per transaction.
// Throughput is one transaction per cycle while the result side keeps up.
// An accepted transaction waits in the input register until the result
// register is free or being drained; then a single combinational pass
// through the free-slot priority encoder and the per-slot compare and
// increment loads the result register. Table state is updated on the same
// edge the result is captured, so back-to-back transactions see each other.
`include "assert_macros.svh"

module periodic_timer_slot_table #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pts_pkg::kind_t     in_kind,
  input  pts_pkg::period_t   in_period_ticks,
  input  pts_pkg::slot_id_t  in_slot_id,
  output logic               out_valid,
  input  logic               out_ready,
  output pts_pkg::grant_t    out_granted_slot,
  output logic               out_table_full,
  output pts_pkg::mask_t     out_fire_mask
);
  import pts_pkg::*;

  // input register
  logic       s0_valid_r;
  kind_t      s0_kind_r;
  period_t    s0_period_r;
  slot_id_t   s0_slot_id_r;

  // result register
  logic       out_valid_r;
  grant_t     out_granted_r;
  logic       out_full_r;
  mask_t      out_mask_r;

  logic             advance;
  slot_cmd_t        cmd;
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] grant_onehot;
  grant_t           grant_idx;
  logic             alloc_full;
  logic [SLOTS-1:0] fire;
  mask_t            fire_mask;
  logic             is_reg;

  // Stage 0 moves into the result register when the result slot is free
  // or being drained this cycle.
  assign advance  = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s0_valid_r <= 1'b1;
    end else if (advance) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_kind_r    <= in_kind;
      s0_period_r  <= in_period_ticks;
      s0_slot_id_r <= in_slot_id;
    end
  end

  // Decode; enables only on the advancing cycle so the bank updates once.
  assign is_reg      = s0_kind_r == KIND_REGISTER;
  assign cmd.reg_en  = advance && is_reg;
  assign cmd.rem_en  = advance && (s0_kind_r == KIND_REMOVE);
  assign cmd.tick_en = advance && (s0_kind_r == KIND_TICK);
  assign cmd.period  = s0_period_r;
  assign cmd.slot_id = s0_slot_id_r;

  pts_alloc #(
    .SLOTS(SLOTS)
  ) u_alloc (
    .active_i      (active),
    .grant_onehot_o(grant_onehot),
    .grant_idx_o   (grant_idx),
    .full_o        (alloc_full)
  );

  pts_slot_bank #(
    .SLOTS(SLOTS)
  ) u_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .grant_onehot_i(grant_onehot),
    .active_o      (active),
    .fire_o        (fire)
  );

  // Only the first eight slots have a bit in the mask.
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < SLOTS) begin : g_bit
      assign fire_mask[b] = fire[b];
    end else begin : g_zero
      assign fire_mask[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_granted_r <= (is_reg && !alloc_full) ? grant_idx : '0;
      out_full_r    <= is_reg && alloc_full;
      out_mask_r    <= fire_mask;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_granted_r;
  assign out_table_full   = out_full_r;
  assign out_fire_mask    = out_mask_r;

  `ASSERT_ON(a_grant_onehot, $onehot0(grant_onehot), "more than one slot granted")
  `ASSERT_ON(a_full_all_active, alloc_full |-> (&active), "full with a free slot")
  `ASSERT_ON(a_reg_sets_active, cmd.reg_en && !alloc_full |=> ((active & $past(grant_onehot)) == $past(grant_onehot)), "granted slot not active")
  `ASSERT_NEVER(a_full_clean, out_valid_r && out_full_r && (out_granted_r != '0 || out_mask_r != '0), "full result carries data")

endmodule

FILE: bench/periodic_timer_slot_table_checker.sv
module periodic_timer_slot_table_checker #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pts_pkg::kind_t     in_kind,
  input  pts_pkg::period_t   in_period_ticks,
  input  pts_pkg::slot_id_t  in_slot_id,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pts_pkg::grant_t    out_granted_slot,
  input  logic               out_table_full,
  input  pts_pkg::mask_t     out_fire_mask,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  typedef struct packed {
    grant_t granted;
    logic   full;
    mask_t  fired;
  } slot_result_t;

  logic    slot_on  [SLOTS];
  period_t slot_per [SLOTS];
  period_t slot_cnt [SLOTS];

  slot_result_t slot_result_q[$];

  // Applies one transaction to the shadow table and returns its result.
  function automatic slot_result_t apply_slot_item(kind_t k, period_t p, slot_id_t id);
    slot_result_t r;
    logic         found;
    r     = '0;
    found = 1'b0;
    case (k)
      KIND_REGISTER: begin
        r.full = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !slot_on[i]) begin
            found       = 1'b1;
            slot_on[i]  = 1'b1;
            slot_per[i] = p;
            slot_cnt[i] = '0;
            r.granted   = grant_t'(i);
            r.full      = 1'b0;
          end
        end
      end
      KIND_REMOVE: begin
        // count is kept on purpose, only active bit and period go
        if (id < SLOTS) begin
          slot_on[id]  = 1'b0;
          slot_per[id] = '0;
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          slot_cnt[i] = slot_cnt[i] + 1'b1;
          if (slot_on[i] && slot_cnt[i] >= slot_per[i]) begin
            slot_cnt[i] = '0;
            if (i < MASK_W) r.fired[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    slot_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_on[i]  = 1'b0;
        slot_per[i] = '0;
        slot_cnt[i] = '0;
      end
      slot_result_q.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (in_valid && in_ready)
        slot_result_q.push_back(apply_slot_item(in_kind, in_period_ticks, in_slot_id));
      if (out_valid && out_ready) begin
        if (slot_result_q.size() == 0) begin
          $error("result transaction with nothing expected: granted_slot %0d table_full %0b fire_mask %h",
                 out_granted_slot, out_table_full, out_fire_mask);
          fail_count++;
        end else begin
          want = slot_result_q.pop_front();
          if (out_granted_slot !== want.granted) begin
            $error("granted_slot: expected %0d, actual %0d", want.granted, out_granted_slot);
            fail_count++;
          end
          if (out_table_full !== want.full) begin
            $error("table_full: expected %0b, actual %0b", want.full, out_table_full);
            fail_count++;
          end
          if (out_fire_mask !== want.fired) begin
            $error("fire_mask: expected %h, actual %h", want.fired, out_fire_mask);
            fail_count++;
          end
        end
      end
      outstanding = slot_result_q.size();
    end
  end

endmodule

FILE: bench/periodic_timer_slot_table_tb.sv
module periodic_timer_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam int SLOTS = 8;
  // kind value with no meaning in the block; must be a no-op with a zero result
  localparam kind_t KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 700;
  // Watchdog budget for the whole run; it leaves a wide margin even with
  // both sides stalling.
  localparam int CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  kind_t    in_kind;
  period_t  in_period_ticks;
  slot_id_t in_slot_id;
  logic     out_valid;
  logic     out_ready = 1'b0;
  grant_t   out_granted_slot;
  logic     out_table_full;
  mask_t    out_fire_mask;

  logic in_taken = 1'b0;   // input transaction completed at the last rising edge
  int   send_idle_pct;
  int   recv_idle_pct;
  int   fail_count;
  int   outstanding;
  int   cycle_cnt;

  periodic_timer_slot_table #(.SLOTS(SLOTS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_period_ticks  (in_period_ticks),
    .in_slot_id       (in_slot_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_table_full   (out_table_full),
    .out_fire_mask    (out_fire_mask)
  );

  periodic_timer_slot_table_checker #(.SLOTS(SLOTS)) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_period_ticks  (in_period_ticks),
    .in_slot_id       (in_slot_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_table_full   (out_table_full),
    .out_fire_mask    (out_fire_mask),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Handshake is sampled on the rising edge with pre-edge values, and read back
  // by the driver at the following falling edge.
  always @(posedge clk) in_taken <= rst_n && in_valid && in_ready;

  // Result side backpressure; redrawn every falling edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog: a hung handshake or lost result ends here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("periodic_timer_slot_table_tb: FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next call can keep it up without a glitch.
  task automatic issue_item(input kind_t k, input period_t p, input slot_id_t id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_period_ticks <= p;
    in_slot_id      <= id;
    do @(negedge clk); while (!in_taken);
  endtask

  initial begin
    int      pick;
    int      reg_pct;
    int      rem_pct;
    kind_t   k;
    period_t p;
    slot_id_t id;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_REGISTER;
    in_period_ticks = '0;
    in_slot_id      = '0;
    send_idle_pct   = 23;
    recv_idle_pct   = 53;
    reg_pct         = 40;
    rem_pct         = 15;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // no-op kind with every input bit set, then removes on an empty table,
    // out-of-range ids at the boundary and at the top
    issue_item(KIND_SPARE,    16'hFFFF, 8'hFF);
    issue_item(KIND_REMOVE,   16'h0000, 8'd255);
    issue_item(KIND_REMOVE,   16'h0000, 8'(SLOTS));
    issue_item(KIND_REMOVE,   16'h0000, 8'd0);
    issue_item(KIND_TICK,     16'h0000, 8'd0);
    // fill every slot: zero period, max period, short and mid periods
    issue_item(KIND_REGISTER, 16'd0,    8'd0);
    issue_item(KIND_REGISTER, 16'hFFFF, 8'd0);
    issue_item(KIND_REGISTER, 16'd1,    8'd0);
    issue_item(KIND_REGISTER, 16'd2,    8'd0);
    issue_item(KIND_REGISTER, 16'd3,    8'd0);
    issue_item(KIND_REGISTER, 16'd4,    8'd0);
    issue_item(KIND_REGISTER, 16'd5,    8'd0);
    issue_item(KIND_REGISTER, 16'h8000, 8'd0);
    // table full: no slot claimed
    issue_item(KIND_REGISTER, 16'd7,    8'd0);
    // zero period fires each tick, others as they come due
    issue_item(KIND_TICK,     16'h0000, 8'd0);
    issue_item(KIND_TICK,     16'h0000, 8'd0);
    // free an active slot and reclaim it; its old count must not leak
    issue_item(KIND_REMOVE,   16'h0000, 8'd1);
    issue_item(KIND_REGISTER, 16'd0,    8'd0);
    issue_item(KIND_TICK,     16'h0000, 8'd0);
    // remove top slot twice: the second one hits a free slot
    issue_item(KIND_REMOVE,   16'h0000, 8'(SLOTS - 1));
    issue_item(KIND_REMOVE,   16'h0000, 8'(SLOTS - 1));
    issue_item(KIND_SPARE,    16'h0000, 8'd0);
    issue_item(KIND_TICK,     16'h0000, 8'd0);
    issue_item(KIND_REGISTER, 16'hAAAA, 8'd0);
    issue_item(KIND_REGISTER, 16'h5555, 8'd0);

    // --- random part ---
    // Three idling phases of equal length; the register/remove mix flips every
    // 50 transactions so the table swings between nearly empty and full.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 23;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n % 50 == 0) begin
        reg_pct = ((n / 50) % 2 == 0) ? 15 : 40;
        rem_pct = 55 - reg_pct;
      end

      pick = $urandom_range(99);
      if (pick < reg_pct)                k = KIND_REGISTER;
      else if (pick < reg_pct + rem_pct) k = KIND_REMOVE;
      else if (pick < 95)                k = KIND_TICK;
      else                               k = KIND_SPARE;

      // mostly short periods so slots actually fire; now and then any value
      pick = $urandom_range(99);
      if (pick < 70)      p = period_t'($urandom_range(6, 0));
      else if (pick < 90) p = period_t'($urandom_range(40, 7));
      else                p = period_t'($urandom);

      pick = $urandom_range(99);
      if (pick < 85) id = slot_id_t'($urandom_range(SLOTS - 1, 0));
      else           id = slot_id_t'($urandom_range(255, SLOTS));

      issue_item(k, p, id);
    end
    in_valid <= 1'b0;

    // drain: every transaction yields exactly one result
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("periodic_timer_slot_table_tb: PASS");
    else
      $display("periodic_timer_slot_table_tb: FAIL");
    $finish;
  end

endmodule
